// ===== rtl/core/b2da_pkg.sv =====
`timescale 1ns / 1ps

package b2da_pkg;

    // port width of the value field; the converter uses the low VALUE_BITS of it
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned ASCII_W  = 6;
    localparam int unsigned DIGIT_W  = 4;

    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_BIT,
        OP_DIGIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dab_ctl;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [DIGIT_W-1:0] top;
    } t_dab_sts;

endpackage

// ===== rtl/core/b2da_if.sv =====
`timescale 1ns / 1ps

interface b2da_in_if;
    logic                        valid;
    logic                        ready;
    logic [b2da_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
    logic                         valid;
    logic                         ready;
    logic [b2da_pkg::ASCII_W-1:0] ascii_digit;
    logic                         last;

    modport source (output valid, output ascii_digit, output last, input ready);
    modport sink   (input valid, input ascii_digit, input last, output ready);
endinterface

// ===== rtl/core/b2da_dabble.sv =====
`timescale 1ns / 1ps

module b2da_dabble #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b2da_pkg::t_dab_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_value,
    output b2da_pkg::t_dab_sts    o_sts
);
    import b2da_pkg::*;

    localparam int unsigned BCD_W = DIGIT_W * MAX_DIGITS;
    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_ovf;
    logic [BCD_W-1:0]      w_corr;

    // add-3 correction on every digit before the doubling shift
    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++) begin : g_corr
            assign w_corr[DIGIT_W*g +: DIGIT_W] =
                (r_bcd[DIGIT_W*g +: DIGIT_W] >= 4'd5) ?
                r_bcd[DIGIT_W*g +: DIGIT_W] + 4'd3 : r_bcd[DIGIT_W*g +: DIGIT_W];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    r_cnt <= CNT_W'(VALUE_BITS);
                    r_ovf <= 1'b0;
                end
                OP_BIT: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    // a carry out of the top digit means digits are being dropped
                    r_ovf <= r_ovf | w_corr[BCD_W-1];
                end
                OP_DIGIT, OP_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                r_bin <= i_value;
                r_bcd <= '0;
            end
            OP_BIT: begin
                r_bin <= r_bin << 1;
                r_bcd <= {w_corr[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            end
            OP_DIGIT: begin
                r_bcd <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
            OP_NONE: begin
            end
        endcase
    end

    assign o_sts.done = (r_cnt == '0);
    assign o_sts.ovf  = r_ovf;
    assign o_sts.top  = r_bcd[BCD_W-1 -: DIGIT_W];

endmodule

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// i_in     in   valid / ready  value[63:0]
// o_out    out  valid / ready  ascii_digit[5:0], last
//
// one item: a load, then the shift-and-correct steps over the VALUE_BITS bits on the
// shared double-dabble register, a step to see the count end, a shift for each leading
// zero stripped, a step to leave stripping and a shift for each digit sent
// i_in.ready is high only while idle; the last digit may still wait in the
// output register when the next item is taken
// a stalled o_out holds the digit shift; reset is synchronous, active low

module binary_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2da_in_if.sink   i_in,
    b2da_out_if.source o_out
);
    import b2da_pkg::*;

    localparam int unsigned LEFT_W = $clog2(MAX_DIGITS + 1);

    t_state             r_state;
    t_state             n_state;
    t_dab_ctl           w_ctl;
    t_dab_sts           w_sts;
    logic [LEFT_W-1:0]  r_left;
    logic               r_out_valid;
    logic [ASCII_W-1:0] r_ascii;
    logic               r_last;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_skip;
    logic               w_last_dig;

    b2da_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_value (i_in.value[VALUE_BITS-1:0]),
        .o_sts   (w_sts)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_last_dig = (r_left == LEFT_W'(1));
    // leading zeros go, unless digits were truncated or only one is left
    assign w_skip     = !w_sts.ovf && (w_sts.top == '0) && !w_last_dig;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_CONV;
            ST_CONV: if (w_sts.done) n_state = ST_SKIP;
            ST_SKIP: if (!w_skip) n_state = ST_EMIT;
            ST_EMIT: if (w_out_free && w_last_dig) n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) w_ctl.op = OP_LOAD;
            ST_CONV: if (!w_sts.done) w_ctl.op = OP_BIT;
            ST_SKIP: if (w_skip) w_ctl.op = OP_DIGIT;
            ST_EMIT: if (w_out_free) w_ctl.op = OP_DIGIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.op == OP_LOAD) begin
                r_left <= LEFT_W'(MAX_DIGITS);
            end else if (w_ctl.op == OP_DIGIT) begin
                r_left <= r_left - LEFT_W'(1);
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_ascii <= ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, w_sts.top};
            r_last  <= w_last_dig;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ascii_digit = r_ascii;
    assign o_out.last        = r_last;

    a_load_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_CONV))
        else $error("accepted item did not start a conversion");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP || r_state == ST_EMIT) |-> (r_left != '0))
        else $error("digit phase with no digits left");

    a_conv_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP || r_state == ST_EMIT) |-> w_sts.done)
        else $error("conversion counter moved during digit phase");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free && w_last_dig) |=> (r_state == ST_IDLE && r_last))
        else $error("last digit did not end the run");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

class decimal_digit_scoreboard;
    typedef logic [b2da_pkg::DIGIT_W-1:0] t_dec;
    typedef logic [b2da_pkg::ASCII_W-1:0] t_ascii;
    typedef struct {
        t_ascii ascii_digit;
        logic   last;
    } t_digit;

    localparam int unsigned DECIMAL_BASE = 10;

    t_digit      digits_due [$];
    int unsigned mismatch_count;
    int unsigned digits_seen;
    int unsigned value_bits;
    int unsigned max_digits;

    function new(int unsigned value_bits_p, int unsigned max_digits_p);
        value_bits     = value_bits_p;
        max_digits     = max_digits_p;
        mismatch_count = 0;
        digits_seen    = 0;
    endfunction

    function int unsigned pending();
        return digits_due.size();
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // split the number into decimal digits and queue them most significant first
    function void note_value(logic [b2da_pkg::VALUE_W-1:0] value);
        logic [b2da_pkg::VALUE_W-1:0] rest;
        t_dec                         lsd_first [$];
        t_digit                       due;
        int                           k;
        rest = value & ({b2da_pkg::VALUE_W{1'b1}} >> (b2da_pkg::VALUE_W - value_bits));
        do begin
            // digits beyond the store depth are dropped from the top
            if (lsd_first.size() < max_digits) begin
                lsd_first.push_back(t_dec'(rest % DECIMAL_BASE));
            end
            rest = rest / DECIMAL_BASE;
        end while (rest != 0);
        for (k = lsd_first.size() - 1; k >= 0; k--) begin
            due.ascii_digit = b2da_pkg::ASCII_ZERO + t_ascii'(lsd_first[k]);
            due.last        = (k == 0);
            digits_due.push_back(due);
        end
    endfunction

    task check_digit(t_ascii ascii_digit, logic last);
        t_digit due;
        digits_seen++;
        if (digits_due.size() == 0) begin
            report($sformatf("digit %0d (code %0d, last %b) arrived with nothing due",
                             digits_seen, ascii_digit, last));
        end else begin
            due = digits_due.pop_front();
            if (ascii_digit !== due.ascii_digit) begin
                report($sformatf("digit %0d: ascii_digit %0d, due %0d",
                                 digits_seen, ascii_digit, due.ascii_digit));
            end
            if (last !== due.last) begin
                report($sformatf("digit %0d: last %b, due %b", digits_seen, last, due.last));
            end
        end
    endtask
endclass

module tb;
    import b2da_pkg::*;

    localparam int unsigned VALUE_BITS       = 64;
    localparam int unsigned MAX_DIGITS       = 20;
    localparam int unsigned STALL_LIMIT      = 4000;
    localparam int unsigned DRAIN_CYCLES     = 200;
    localparam int unsigned RANDOM_PER_PHASE = 76;

    localparam logic [VALUE_W-1:0] CORNERS [18] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'd11,
        64'd99,
        64'd100,
        64'd1000000000,
        64'd1234567890,
        64'd9999999999999999999,
        64'd10000000000000000000,
        64'd12345678901234567890,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555,
        64'd18446744073709551614,
        64'hFFFF_FFFF_FFFF_FFFF
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    decimal_digit_scoreboard sb;

    b2da_in_if  in_ch ();
    b2da_out_if out_ch ();

    binary_to_decimal_ascii_unit #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check on accepted digits, and watchdog on accepted items of either channel
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_digit(out_ch.ascii_digit, out_ch.last);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("binary_to_decimal_ascii_unit regression: fail");
            $finish;
        end
    end

    // mix of full-width values, short values, powers of ten and the values just below them
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] tens;
        int unsigned        sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            tens = 64'd1;
            repeat ($urandom_range(0, 19)) tens = tens * 10;
            return tens - $urandom_range(0, 1);
        end
        if (sel < 4) begin
            return raw;
        end
        return raw >> $urandom_range(1, 63);
    endfunction

    task automatic send_value(logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            in_ch.value = {$urandom, $urandom};
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = value;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_value(value);
        @(negedge i_clk);
    endtask

    task automatic run_random(int unsigned items, int unsigned idle_pct,
                              int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_value(random_value());
    endtask

    initial begin
        sb           = new(VALUE_BITS, MAX_DIGITS);
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (CORNERS[i]) send_value(CORNERS[i]);

        run_random(RANDOM_PER_PHASE, 0, 0);
        run_random(RANDOM_PER_PHASE, 69, 0);
        run_random(RANDOM_PER_PHASE, 0, 69);
        run_random(RANDOM_PER_PHASE, 33, 33);
        in_ch.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        // let any stray digit show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("binary_to_decimal_ascii_unit regression: pass");
        end else begin
            $display("binary_to_decimal_ascii_unit regression: fail");
        end
        $finish;
    end
endmodule
